>>> hw/rtl/nsc_pkg.sv
// Shared types, codes and constants of the neutron collision step core.
`timescale 1ns / 1ps

package nsc_pkg;

    // Cross-section table geometry
    localparam int TBL_DEPTH = 1024;
    localparam int TBL_AW    = $clog2(TBL_DEPTH);
    // Index width able to hold the load index and the depth itself
    localparam int IDX_EXT_W = (TBL_AW + 1 > 11) ? TBL_AW + 1 : 11;

    // Field widths
    localparam int E_W     = 32;   // energy, Q10.22
    localparam int XS_W    = 32;   // cross section, Q16.16
    localparam int RND_W   = 16;   // random fraction, Q0.16
    localparam int LIDX_W  = 10;   // load index
    localparam int CNT_W   = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W   = 32;
    localparam int IN_TDATA_W  = 128;
    localparam int OUT_TDATA_W = 64;

    // Input word layout inside s_tdata
    localparam int IN_IDX_LSB = 0;
    localparam int IN_EL_LSB  = IN_IDX_LSB + LIDX_W;
    localparam int IN_AB_LSB  = IN_EL_LSB + XS_W;
    localparam int IN_RN_LSB  = IN_AB_LSB + XS_W;
    localparam int IN_RR_LSB  = IN_RN_LSB + RND_W;
    localparam int IN_RE_LSB  = IN_RR_LSB + RND_W;

    // Opcodes carried in s_tuser
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_COLLIDE = 1'b1;

    // Event kinds carried in m_tuser
    localparam logic [1:0] EV_HSCAT = 2'd0;
    localparam logic [1:0] EV_USCAT = 2'd1;
    localparam logic [1:0] EV_ABS   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CUTOFF = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_H_XS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_H_DEN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_U_DEN  = 3'd4;

    // Reset values of the configuration registers
    localparam logic [E_W-1:0]  START_RST  = 32'd4194304000;  // 1000 eV
    localparam logic [E_W-1:0]  CUTOFF_RST = 32'd4194304;     // 1 eV
    localparam logic [XS_W-1:0] H_XS_RST   = 32'd1310720;     // 20
    localparam logic [XS_W-1:0] H_DEN_RST  = 32'd655360;      // 10
    localparam logic [XS_W-1:0] U_DEN_RST  = 32'd65536;       // 1

    // Fractional energy loss on uranium, 1 - 237^2/239^2 in Q0.32
    localparam logic [31:0] FRAC_K = 32'((64'd952 << 32) / 64'd57121);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UTERM,
        ST_TOTAL,
        ST_NUC,
        ST_DONE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load_en;   // write one table entry
        logic start;     // latch a collide word, issue table read
        logic step_u;    // uranium term and energy loss
        logic step_t;    // total cross section and absorption test
        logic step_n;    // nuclide test
        logic finish;    // commit result and state
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_busy;  // result register full and not being taken
        logic out_valid;
    } status_t;

endpackage

>>> hw/rtl/nsc_ctrl.sv
// Sequencer for the collision step: accepts words and steps the datapath.
`timescale 1ns / 1ps

module nsc_ctrl
    import nsc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    input  logic    op,
    output logic    s_tready,
    input  status_t stat,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && (op == OP_COLLIDE))
                begin
                    state_next = ST_UTERM;
                end
            end
            ST_UTERM: state_next = ST_TOTAL;
            ST_TOTAL: state_next = ST_NUC;
            ST_NUC:   state_next = ST_DONE;
            ST_DONE:
            begin
                if (!stat.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.load_en = s_tvalid && (op == OP_LOAD);
                cmd.start   = s_tvalid && (op == OP_COLLIDE);
            end
            ST_UTERM: cmd.step_u = 1'b1;
            ST_TOTAL: cmd.step_t = 1'b1;
            ST_NUC:   cmd.step_n = 1'b1;
            ST_DONE:  cmd.finish = !stat.out_busy;
            default:  cmd = '0;
        endcase
    end

endmodule

>>> hw/rtl/nsc_dpath.sv
// Datapath: tables, configuration, collision arithmetic and result register.
`timescale 1ns / 1ps

module nsc_dpath
    import nsc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cmd_t                   cmd,
    output status_t                stat,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]       cfg_wdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic [1:0]             m_tuser,
    output logic                   m_tlast
);

    // Configuration
    logic [E_W-1:0]  start_reg;
    logic [E_W-1:0]  cutoff_reg;
    logic [XS_W-1:0] h_xs_reg;
    logic [XS_W-1:0] h_den_reg;
    logic [XS_W-1:0] u_den_reg;

    // Neutron state
    logic [E_W-1:0]   energy_reg;
    logic [E_W-1:0]   energy_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // Tables
    logic [XS_W-1:0] el_mem [TBL_DEPTH];
    logic [XS_W-1:0] ab_mem [TBL_DEPTH];
    logic [XS_W-1:0] el_rd_reg;
    logic [XS_W-1:0] ab_rd_reg;

    // Working registers
    logic [RND_W-1:0] rnuc_reg;
    logic [RND_W-1:0] rrea_reg;
    logic [E_W-1:0]   t_reg;
    logic [47:0]      hterm_reg;
    logic [32:0]      su_reg;
    logic [XS_W-1:0]  ab_reg;
    logic [48:0]      uterm_reg;
    logic [E_W-1:0]   d_reg;
    logic [49:0]      total_reg;
    logic             abs_hit_reg;
    logic             hit_u_reg;

    // Result register
    logic             out_valid_reg;
    logic [E_W-1:0]   out_energy_reg;
    logic [1:0]       out_kind_reg;
    logic             out_fin_reg;
    logic [CNT_W-1:0] out_count_reg;

    // Input fields
    logic [LIDX_W-1:0] in_index;
    logic [XS_W-1:0]   in_el;
    logic [XS_W-1:0]   in_ab;
    logic [RND_W-1:0]  in_rnuc;
    logic [RND_W-1:0]  in_rrea;
    logic [RND_W-1:0]  in_ren;

    assign in_index = s_tdata[IN_IDX_LSB +: LIDX_W];
    assign in_el    = s_tdata[IN_EL_LSB +: XS_W];
    assign in_ab    = s_tdata[IN_AB_LSB +: XS_W];
    assign in_rnuc  = s_tdata[IN_RN_LSB +: RND_W];
    assign in_rrea  = s_tdata[IN_RR_LSB +: RND_W];
    assign in_ren   = s_tdata[IN_RE_LSB +: RND_W];

    // Table addresses: load index checked against depth, read index saturated
    logic [IDX_EXT_W-1:0] ld_ext;
    logic                 ld_ok;
    logic [9:0]           rd_whole;
    logic [9:0]           rd_m1;
    logic [IDX_EXT_W-1:0] rd_ext;
    logic [IDX_EXT_W-1:0] rd_sat;
    logic [TBL_AW-1:0]    wr_addr;
    logic [TBL_AW-1:0]    rd_addr;

    always_comb
    begin
        ld_ext   = IDX_EXT_W'(in_index);
        ld_ok    = ld_ext < IDX_EXT_W'(TBL_DEPTH);
        wr_addr  = ld_ext[TBL_AW-1:0];
        rd_whole = energy_reg[E_W-1:22];
        rd_m1    = (rd_whole == 10'd0) ? 10'd0 : rd_whole - 10'd1;
        rd_ext   = IDX_EXT_W'(rd_m1);
        rd_sat   = (rd_ext > IDX_EXT_W'(TBL_DEPTH - 1)) ? IDX_EXT_W'(TBL_DEPTH - 1) : rd_ext;
        rd_addr  = rd_sat[TBL_AW-1:0];
    end

    // Table memories: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.load_en && ld_ok)
        begin
            el_mem[wr_addr] <= in_el;
            ab_mem[wr_addr] <= in_ab;
        end
        if (cmd.start)
        begin
            el_rd_reg <= el_mem[rd_addr];
            ab_rd_reg <= ab_mem[rd_addr];
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg  <= START_RST;
            cutoff_reg <= CUTOFF_RST;
            h_xs_reg   <= H_XS_RST;
            h_den_reg  <= H_DEN_RST;
            u_den_reg  <= U_DEN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_START:  start_reg  <= cfg_wdata;
                REG_CUTOFF: cutoff_reg <= cfg_wdata;
                REG_H_XS:   h_xs_reg   <= cfg_wdata;
                REG_H_DEN:  h_den_reg  <= cfg_wdata;
                REG_U_DEN:  u_den_reg  <= cfg_wdata;
                default:    ;
            endcase
        end
    end

    // Start step: scattered energy on hydrogen and the hydrogen term
    logic [47:0] t_prod;
    logic [63:0] h_prod;

    assign t_prod = energy_reg * in_ren;
    assign h_prod = h_xs_reg * h_den_reg;

    // Uranium step: sU, uranium term, energy loss on uranium
    logic [32:0] su_c;
    logic [63:0] u_prod;
    logic [48:0] u_hi;
    logic [63:0] k_prod;

    assign su_c   = {1'b0, el_rd_reg} + {1'b0, ab_rd_reg};
    assign u_prod = su_c[31:0] * u_den_reg;
    assign u_hi   = su_c[32] ? {1'b0, u_den_reg, 16'd0} : 49'd0;
    assign k_prod = t_reg * FRAC_K;

    // Total step: absorption test on uranium
    logic [32:0] rea_hi;
    logic [31:0] rea_lo;
    logic [33:0] rea_frac;

    assign rea_hi   = rrea_reg * su_reg[32:16];
    assign rea_lo   = rrea_reg * su_reg[15:0];
    assign rea_frac = 34'(rea_hi) + 34'(rea_lo[31:16]);

    // Nuclide step: hydrogen or uranium
    logic [49:0] nuc_hi;
    logic [31:0] nuc_lo;
    logic [50:0] nuc_frac;

    assign nuc_hi   = rnuc_reg * total_reg[49:16];
    assign nuc_lo   = rnuc_reg * total_reg[15:0];
    assign nuc_frac = 51'(nuc_hi) + 51'(nuc_lo[31:16]);

    // Advance the working registers one step at a time
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            rnuc_reg  <= in_rnuc;
            rrea_reg  <= in_rrea;
            t_reg     <= t_prod[47:16];
            hterm_reg <= h_prod[63:16];
        end
        if (cmd.step_u)
        begin
            su_reg    <= su_c;
            ab_reg    <= ab_rd_reg;
            uterm_reg <= u_hi + 49'(u_prod[63:16]);
            d_reg     <= k_prod[63:32];
        end
        if (cmd.step_t)
        begin
            total_reg   <= 50'(uterm_reg) + 50'(hterm_reg);
            abs_hit_reg <= rea_frac < 34'(ab_reg);
        end
        if (cmd.step_n)
        begin
            hit_u_reg <= nuc_frac < 51'(uterm_reg);
        end
    end

    // Resolve the event
    logic [1:0]     kind_c;
    logic [E_W-1:0] ne_c;
    logic           fin_c;

    always_comb
    begin
        if (!hit_u_reg)
        begin
            kind_c = EV_HSCAT;
            ne_c   = t_reg;
        end
        else if (abs_hit_reg)
        begin
            kind_c = EV_ABS;
            ne_c   = energy_reg;
        end
        else
        begin
            kind_c = EV_USCAT;
            ne_c   = energy_reg - d_reg;
        end
        fin_c       = (kind_c == EV_ABS) || (ne_c <= cutoff_reg);
        energy_next = fin_c ? start_reg : ne_c;
        count_next  = count_reg;
        if ((kind_c == EV_ABS) && (count_reg != '1))
        begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    // Commit neutron state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            energy_reg <= START_RST;
            count_reg  <= '0;
        end
        else if (cmd.finish)
        begin
            energy_reg <= energy_next;
            count_reg  <= count_next;
        end
    end

    // Result register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_energy_reg <= ne_c;
            out_kind_reg   <= kind_c;
            out_fin_reg    <= fin_c;
            out_count_reg  <= count_next;
        end
    end

    assign stat.out_valid = out_valid_reg;
    assign stat.out_busy  = out_valid_reg && !m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_count_reg, out_energy_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_fin_reg;

endmodule

>>> hw/rtl/neutron_slowdown_collision_step_core.sv
// Top level of the neutron slowing-down collision step core.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | s_tdata, s_tuser = opcode
//  m_      | out | m_tvalid/m_tready  | m_tdata, m_tuser = event kind, m_tlast
//  cfg_    | in  | cfg_we             | cfg_index, cfg_wdata
//
// A load word writes one entry of both tables.
// A collide word keeps s_tready low while it steps through the table read on
// acceptance, then the uranium term, total cross section, nuclide test and
// commit; the result register loads on commit.
// The commit step waits while the result register holds a word not yet taken.
// Reset restores the configuration defaults, the birth energy, a zero count and an
// empty result register; tables are not cleared.
`timescale 1ns / 1ps

module neutron_slowdown_collision_step_core
    import nsc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [9:0] table_index, [41:10] elastic_value, [73:42] absorb_value,
    // [89:74] rand_nuclide, [105:90] rand_reaction, [121:106] rand_energy
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // [0] opcode
    input  logic                   s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [31:0] new_energy, [63:32] absorbed_total
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // [1:0] event_kind
    output logic [1:0]             m_tuser,
    output logic                   m_tlast,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]       cfg_wdata
);

    cmd_t    cmd;
    status_t stat;

    nsc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .op       (s_tuser),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    nsc_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

`ifndef SYNTHESIS
    // A collide word makes the core busy on the next cycle
    a_busy_after_collide: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == OP_COLLIDE)) |=> !s_tready)
        else $error("core ready right after accepting a collide word");

    // A commit always lands a word in the result register
    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> (m_tvalid && stat.out_valid))
        else $error("commit did not load the result register");

    // An absorption always ends the neutron
    a_abs_finishes: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == EV_ABS)) |-> m_tlast)
        else $error("absorbed neutron not marked finished");

    // No input is taken while a result is being committed
    a_no_accept_commit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !s_tready)
        else $error("input accepted during commit");
`endif

endmodule
